@@ src/dlsq_pkg.sv @@
// Package for the delta list sleep queue: operation and status codes,
// transaction payload structs and the sequencer state type. No dependencies.
package dlsq_pkg;

	// operation codes carried by a command transaction
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_TICK   = 2'd1,
		OP_POP    = 2'd2,
		OP_REMOVE = 2'd3
	} op_t;

	// status codes carried by a response transaction
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_MISS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	// command payload
	typedef struct packed {
		op_t         operation;
		logic [7:0]  thread_id;
		logic [15:0] delay;
	} cmd_t;

	// response payload
	typedef struct packed {
		status_t     status;
		logic [7:0]  popped_id;
		logic        queue_empty;
		logic [15:0] head_remaining;
		logic [4:0]  entry_count;
	} rsp_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_INS_WR,
		S_TICK,
		S_HEAD_RD,
		S_HEAD_CAP
	} state_t;

endpackage

@@ src/dlsq_stream_if.sv @@
// Valid/ready stream channel used for command and response transactions.
// The payload type is set per instance; no package dependency.
interface dlsq_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

@@ src/dlsq_store.sv @@
// Entry memory of the sleep queue: id and delta arrays behind one write
// port and one registered read port. Depends on nothing.
module dlsq_store #(
	parameter int MAX_ENTRIES = 16,
	parameter int DELAY_BITS = 16,
	parameter int ID_BITS = 8,
	localparam int IDX_W = $clog2(MAX_ENTRIES)
) (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [IDX_W-1:0]      rd_addr,
	output logic [ID_BITS-1:0]    rd_id,
	output logic [DELAY_BITS-1:0] rd_dl,
	input  logic                  wr_en,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [ID_BITS-1:0]    wr_id,
	input  logic [DELAY_BITS-1:0] wr_dl
);

	logic [ID_BITS-1:0]    id_mem [MAX_ENTRIES];
	logic [DELAY_BITS-1:0] dl_mem [MAX_ENTRIES];
	logic [ID_BITS-1:0]    rd_id_q;
	logic [DELAY_BITS-1:0] rd_dl_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_mem[wr_addr] <= wr_id;
			dl_mem[wr_addr] <= wr_dl;
		end
	end

	// read port, registered, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_id_q <= id_mem[rd_addr];
			rd_dl_q <= dl_mem[rd_addr];
		end
	end

	assign rd_id = rd_id_q;
	assign rd_dl = rd_dl_q;

endmodule

@@ src/dlsq_ctrl.sv @@
// Sequencer of the sleep queue: scans, shifts and patches entries in the
// entry memory and builds the response. Depends on dlsq_pkg, dlsq_stream_if.
module dlsq_ctrl
	import dlsq_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int DELAY_BITS = 16,
	parameter int ID_BITS = 8,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	dlsq_stream_if.sink           cmd,
	dlsq_stream_if.source         rsp,
	output logic                  st_rd_en,
	output logic [IDX_W-1:0]      st_rd_addr,
	input  logic [ID_BITS-1:0]    st_rd_id,
	input  logic [DELAY_BITS-1:0] st_rd_dl,
	output logic                  st_wr_en,
	output logic [IDX_W-1:0]      st_wr_addr,
	output logic [ID_BITS-1:0]    st_wr_id,
	output logic [DELAY_BITS-1:0] st_wr_dl
);

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	// control state
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_vld_q;
	logic             chk_vld_s1;
	logic             issue_q;
	logic             mv_vld_s1;

	// per-transaction working registers
	op_t                   op_q;
	logic [ID_BITS-1:0]    id_q;
	logic [DELAY_BITS-1:0] rem_q;
	logic [DELAY_BITS-1:0] succ_q;
	logic [DELAY_BITS-1:0] mdel_q;
	logic                  fold_q;
	status_t               status_q;
	logic [ID_BITS-1:0]    popped_q;
	logic [CNT_W-1:0]      pos_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [CNT_W-1:0]      chk_idx_s1;
	logic [CNT_W-1:0]      sh_idx_q;
	logic [CNT_W-1:0]      mv_idx_s1;
	rsp_t                  rsp_q;

	// decoded conditions
	logic                  cmd_fire;
	logic                  cap_ok;
	logic [ID_BITS-1:0]    c_id;
	logic [DELAY_BITS-1:0] c_dly;
	logic                  cnt_zero;
	logic                  cnt_full;
	logic                  is_ins;
	logic                  chk_hit;
	logic                  scan_end;
	logic [CNT_W-1:0]      chk_nxt;
	logic                  has_tail;
	logic                  scan_issue;
	logic                  sh_last;
	logic                  sh_done;
	logic [CNT_W-1:0]      ins_dst;
	logic [CNT_W-1:0]      rm_dst;
	logic [DELAY_BITS:0]   fold_sum;
	logic [DELAY_BITS-1:0] fold_dl;

	assign cmd.ready  = (state_q == S_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign cap_ok     = !rsp_vld_q || rsp.ready;
	assign c_id       = ID_BITS'(cmd.data.thread_id);
	assign c_dly      = DELAY_BITS'(cmd.data.delay);
	assign cnt_zero   = (cnt_q == '0);
	assign cnt_full   = (cnt_q == CNT_MAX);
	assign is_ins     = (op_q == OP_INSERT);

	// scan check: insert stops at the first larger delta, remove at the id,
	// pop at the head
	assign chk_hit    = chk_vld_s1 && (is_ins ? (rem_q < st_rd_dl)
	                                          : ((op_q == OP_POP) || (st_rd_id == id_q)));
	assign scan_end   = !chk_vld_s1;
	assign chk_nxt    = chk_idx_s1 + CNT_ONE;
	assign has_tail   = (chk_nxt < cnt_q);
	assign scan_issue = (state_q == S_SCAN) && !chk_hit && (rd_idx_q < cnt_q);

	// shift walk: insert moves entries up from the tail, removal moves them down
	assign sh_last    = is_ins ? (sh_idx_q == pos_q) : (sh_idx_q == cnt_q - CNT_ONE);
	assign sh_done    = !issue_q && !mv_vld_s1;
	assign ins_dst    = mv_idx_s1 + CNT_ONE;
	assign rm_dst     = mv_idx_s1 - CNT_ONE;

	// successor fold on removal, saturating
	assign fold_sum   = {1'b0, st_rd_dl} + {1'b0, mdel_q};
	assign fold_dl    = fold_sum[DELAY_BITS] ? '1 : fold_sum[DELAY_BITS-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					case (cmd.data.operation)
						OP_INSERT: begin
							if ((c_dly == '0) || cnt_full) state_d = S_HEAD_RD;
							else state_d = S_SCAN;
						end
						OP_TICK:   state_d = cnt_zero ? S_HEAD_RD : S_TICK;
						default:   state_d = S_SCAN;
					endcase
				end
			end
			S_SCAN: begin
				if (chk_hit) begin
					if (is_ins || has_tail) state_d = S_SHIFT;
					else state_d = S_HEAD_RD;
				end else if (scan_end) begin
					state_d = is_ins ? S_INS_WR : S_HEAD_RD;
				end
			end
			S_SHIFT: begin
				if (sh_done) state_d = is_ins ? S_INS_WR : S_HEAD_RD;
			end
			S_INS_WR:   state_d = S_HEAD_RD;
			S_TICK:     state_d = S_HEAD_RD;
			S_HEAD_RD:  state_d = S_HEAD_CAP;
			S_HEAD_CAP: begin
				if (cap_ok) state_d = S_IDLE;
			end
			default:    state_d = S_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		st_rd_en   = 1'b0;
		st_rd_addr = '0;
		st_wr_en   = 1'b0;
		st_wr_addr = '0;
		st_wr_id   = st_rd_id;
		st_wr_dl   = st_rd_dl;
		case (state_q)
			S_IDLE: begin
				st_rd_en = cmd_fire && !cnt_zero;
			end
			S_SCAN: begin
				st_rd_en   = scan_issue;
				st_rd_addr = rd_idx_q[IDX_W-1:0];
			end
			S_SHIFT: begin
				st_rd_en   = issue_q;
				st_rd_addr = sh_idx_q[IDX_W-1:0];
				st_wr_en   = mv_vld_s1;
				if (is_ins) begin
					st_wr_addr = ins_dst[IDX_W-1:0];
					if (mv_idx_s1 == pos_q) st_wr_dl = succ_q;
				end else begin
					st_wr_addr = rm_dst[IDX_W-1:0];
					if (fold_q && (rm_dst == pos_q)) st_wr_dl = fold_dl;
				end
			end
			S_INS_WR: begin
				st_wr_en   = 1'b1;
				st_wr_addr = pos_q[IDX_W-1:0];
				st_wr_id   = id_q;
				st_wr_dl   = rem_q;
			end
			S_TICK: begin
				st_wr_en = (st_rd_dl != '0);
				st_wr_dl = st_rd_dl - DELAY_BITS'(1);
			end
			S_HEAD_RD: begin
				st_rd_en = !cnt_zero;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			rsp_vld_q  <= 1'b0;
			chk_vld_s1 <= 1'b0;
			issue_q    <= 1'b0;
			mv_vld_s1  <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= ((state_q == S_IDLE) && cmd_fire && !cnt_zero) || scan_issue;
			mv_vld_s1  <= (state_q == S_SHIFT) && issue_q;

			if (state_q == S_SCAN && chk_hit) issue_q <= is_ins || has_tail;
			else if (state_q == S_SHIFT) issue_q <= issue_q && !sh_last;
			else issue_q <= 1'b0;

			if (state_q == S_INS_WR) cnt_q <= cnt_q + CNT_ONE;
			else if ((state_q == S_SCAN) && chk_hit && !is_ins && !has_tail)
				cnt_q <= cnt_q - CNT_ONE;
			else if ((state_q == S_SHIFT) && sh_done && !is_ins)
				cnt_q <= cnt_q - CNT_ONE;

			if ((state_q == S_HEAD_CAP) && cap_ok) rsp_vld_q <= 1'b1;
			else if (rsp.ready) rsp_vld_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					op_q       <= cmd.data.operation;
					id_q       <= c_id;
					rem_q      <= c_dly;
					fold_q     <= (cmd.data.operation == OP_REMOVE);
					popped_q   <= '0;
					rd_idx_q   <= CNT_ONE;
					chk_idx_s1 <= '0;
					status_q   <= ST_OK;
					case (cmd.data.operation)
						OP_INSERT: begin
							if (c_dly == '0) status_q <= ST_ZERO;
							else if (cnt_full) status_q <= ST_FULL;
						end
						OP_TICK: begin
							if (cnt_zero) status_q <= ST_MISS;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (scan_issue) begin
					rd_idx_q   <= rd_idx_q + CNT_ONE;
					chk_idx_s1 <= rd_idx_q;
				end
				if (chk_hit) begin
					pos_q  <= chk_idx_s1;
					succ_q <= st_rd_dl - rem_q;
					mdel_q <= st_rd_dl;
					if (op_q == OP_POP) popped_q <= st_rd_id;
					sh_idx_q <= is_ins ? (cnt_q - CNT_ONE) : chk_nxt;
				end else if (chk_vld_s1) begin
					if (is_ins) rem_q <= rem_q - st_rd_dl;
				end else begin
					if (is_ins) pos_q <= cnt_q;
					else status_q <= ST_MISS;
				end
			end
			S_SHIFT: begin
				if (issue_q) begin
					sh_idx_q <= is_ins ? (sh_idx_q - CNT_ONE) : (sh_idx_q + CNT_ONE);
				end
				mv_idx_s1 <= sh_idx_q;
			end
			S_HEAD_CAP: begin
				if (cap_ok) begin
					rsp_q.status         <= status_q;
					rsp_q.popped_id      <= 8'(popped_q);
					rsp_q.queue_empty    <= cnt_zero;
					rsp_q.head_remaining <= cnt_zero ? 16'd0 : 16'(st_rd_dl);
					rsp_q.entry_count    <= 5'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	// occupancy never passes the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("entry count above capacity");

	// occupancy moves by at most one entry per change
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
			((cnt_q == $past(cnt_q) + CNT_ONE) || (cnt_q == $past(cnt_q) - CNT_ONE)))
		else $error("entry count jumped");

	// read and write never hit the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(st_wr_en && st_rd_en) |-> (st_wr_addr != st_rd_addr))
		else $error("read and write on the same entry");

	// memory is only written while a transaction is in work
	a_idle_no_wr: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) || (state_q == S_HEAD_CAP)) |-> !st_wr_en)
		else $error("entry write outside an operation");

endmodule

@@ src/delta_list_sleep_queue_unit.sv @@
// Delta list sleep queue, top level: command and response channels around
// the sequencer and the entry memory. Depends on dlsq_pkg, dlsq_stream_if,
// dlsq_ctrl and dlsq_store.
//
// Usage:
//   cmd carries one operation per transaction (insert, tick, pop, remove by
//   id) with a thread id and a delay; rsp returns exactly one result per
//   command: status, popped id, empty flag, head delta and entry count.
//   Commands are taken one at a time; cmd.ready is high while the sequencer
//   is free, also while the previous result still waits in the output register.
// Steps, with N entries queued, from the command to rsp.valid:
//   tick: head decrement, head read, capture; commands rejected up front and a
//   tick on an empty queue go straight to the head read and capture.
//   insert, pop and remove: a walk through the entry memory, its length set
//   by N (scan for the position, then one entry moved per cycle), before the
//   head read and capture.
// Reset: arst_n clears the entry count and all handshake state; the queue
//   comes out empty and memory contents are not touched.
// Stall: a result held by a low rsp.ready stays in the output register; the
//   next command is worked on and waits at the end for the register to free.
module delta_list_sleep_queue_unit
	import dlsq_pkg::*;
#(
	parameter int MAX_ENTRIES = 16,
	parameter int DELAY_BITS = 16,
	parameter int ID_BITS = 8
) (
	input logic           clk,
	input logic           arst_n,
	dlsq_stream_if.sink   cmd,
	dlsq_stream_if.source rsp
);

	localparam int IDX_W = $clog2(MAX_ENTRIES);

	// entry memory port
	logic                  st_rd_en;
	logic [IDX_W-1:0]      st_rd_addr;
	logic [ID_BITS-1:0]    st_rd_id;
	logic [DELAY_BITS-1:0] st_rd_dl;
	logic                  st_wr_en;
	logic [IDX_W-1:0]      st_wr_addr;
	logic [ID_BITS-1:0]    st_wr_id;
	logic [DELAY_BITS-1:0] st_wr_dl;

	// sequencer
	dlsq_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.DELAY_BITS  (DELAY_BITS),
		.ID_BITS     (ID_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.st_rd_en   (st_rd_en),
		.st_rd_addr (st_rd_addr),
		.st_rd_id   (st_rd_id),
		.st_rd_dl   (st_rd_dl),
		.st_wr_en   (st_wr_en),
		.st_wr_addr (st_wr_addr),
		.st_wr_id   (st_wr_id),
		.st_wr_dl   (st_wr_dl)
	);

	// entry memory
	dlsq_store #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.DELAY_BITS  (DELAY_BITS),
		.ID_BITS     (ID_BITS)
	) u_store (
		.clk     (clk),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_id   (st_rd_id),
		.rd_dl   (st_rd_dl),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_id   (st_wr_id),
		.wr_dl   (st_wr_dl)
	);

endmodule
